// ===== hw/rtl/quaternion_slerp_unit_defines.svh =====
// Assertion macros shared by the slerp unit. They sample on clk and hold off while rst_n is low.
`ifndef QUATERNION_SLERP_UNIT_DEFINES_SVH
`define QUATERNION_SLERP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qsu_pkg.sv =====
package qsu_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int WORK_BITS = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_BITS = 31;
    localparam int QUOT_BITS = 32;
    localparam logic [29:0] NEAR_LIMIT = 30'd1073204953;
    localparam logic [33:0] CORDIC_START = 34'd652032874;
    localparam logic [16:0] BLEND_ONE = 17'd65536;

    localparam int ST_PROD = 1;
    localparam int ST_DOT = 2;
    localparam int ST_SQ = 3;
    localparam int ST_RES = 4;
    localparam int ST_RSQ = 5;
    localparam int ST_LEN = 6;
    localparam int ISQ0 = 7;
    localparam int ISQ_LAST = ISQ0 + ROOT_BITS - 1;
    localparam int CV0 = ISQ_LAST + 1;
    localparam int CV_LAST = CV0 + CORDIC_STEPS - 1;
    localparam int ST_SPLIT = CV_LAST + 1;
    localparam int RT0 = ST_SPLIT + 1;
    localparam int RT_LAST = RT0 + CORDIC_STEPS - 1;
    localparam int DV0 = RT_LAST + 1;
    localparam int DV_LAST = DV0 + QUOT_BITS - 1;
    localparam int ST_MUL = DV_LAST + 1;
    localparam int ST_OUT = ST_MUL + 1;
    localparam int LAST_STAGE = ST_OUT;

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] first_w;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic signed [15:0] second_w;
        logic [16:0]        blend;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic signed [15:0] out_w;
    } out_t;

    typedef struct packed {
        logic [61:0] rem;
        logic [30:0] root;
    } root_t;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
        logic [32:0] z;
    } cordic_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] lo;
        logic [31:0] quo;
    } div_t;

    typedef struct packed {
        logic [3:0][15:0] qa;
        logic [3:0][16:0] qb;
        logic [16:0]      t;
        logic [3:0][33:0] dp;
        logic             near;
        logic [29:0]      dq;
        logic [59:0]      dsq;
        logic [3:0][35:0] lp;
        logic [3:0][17:0] res;
        logic [3:0][35:0] sq;
        logic             zero;
        root_t            sroot;
        root_t            lroot;
        cordic_t          vec;
        logic [32:0]      tt;
        cordic_t          rota;
        cordic_t          rotb;
        div_t [5:0]       dv;
        logic [5:0]       dneg;
        logic [3:0][50:0] pa;
        logic [3:0][50:0] pb;
        logic [3:0][15:0] o;
    } pipe_t;

    function automatic logic [32:0] arc_step(int i);
        logic [32:0] a;
        case (i)
            0: a = 33'd843314857;
            1: a = 33'd497837829;
            2: a = 33'd263043837;
            3: a = 33'd133525159;
            4: a = 33'd67021687;
            5: a = 33'd33543516;
            6: a = 33'd16775851;
            7: a = 33'd8388437;
            8: a = 33'd4194283;
            9: a = 33'd2097149;
            default: a = 33'd1 << (WORK_BITS - i);
        endcase
        return a;
    endfunction

    function automatic root_t root_step(root_t s, int k);
        root_t r;
        logic [61:0] trial;
        trial = ({31'd0, s.root} << (k + 1)) | (62'd1 << (2 * k));
        r = s;
        if (s.rem >= trial)
        begin
            r.rem = s.rem - trial;
            r.root = s.root | (31'd1 << k);
        end
        return r;
    endfunction

    function automatic cordic_t vector_step(cordic_t c, int i);
        cordic_t r;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [32:0] z;
        logic signed [32:0] a;
        x = $signed(c.x);
        y = $signed(c.y);
        z = $signed(c.z);
        a = $signed(arc_step(i));
        dx = y >>> i;
        dy = x >>> i;
        if (!y[33])
        begin
            x = x + dx;
            y = y - dy;
            z = z + a;
        end
        else
        begin
            x = x - dx;
            y = y + dy;
            z = z - a;
        end
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    function automatic cordic_t rotate_step(cordic_t c, int i);
        cordic_t r;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [32:0] z;
        logic signed [32:0] a;
        x = $signed(c.x);
        y = $signed(c.y);
        z = $signed(c.z);
        a = $signed(arc_step(i));
        dx = y >>> i;
        dy = x >>> i;
        if (!z[32])
        begin
            x = x - dx;
            y = y + dy;
            z = z - a;
        end
        else
        begin
            x = x + dx;
            y = y - dy;
            z = z + a;
        end
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    function automatic div_t div_step(div_t s, logic [30:0] d);
        div_t r;
        logic [31:0] trial;
        trial = {s.rem[30:0], s.lo[31]};
        r.lo = {s.lo[30:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            r.rem = trial - {1'b0, d};
            r.quo = {s.quo[30:0], 1'b1};
        end
        else
        begin
            r.rem = trial;
            r.quo = {s.quo[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [15:0] saturate_one(logic signed [63:0] v, int frac);
        logic signed [63:0] one;
        logic signed [63:0] r;
        one = 64'sd1 <<< frac;
        if (v > one)
            r = one;
        else if (v < -one)
            r = -one;
        else
            r = v;
        return r[15:0];
    endfunction

endpackage

// ===== hw/rtl/quaternion_slerp_unit.sv =====
// Spherical linear interpolation of two unit quaternions in signed fixed point.
// Input: drive operands and raise start for one cycle per beat. busy never rises,
// so a beat is taken on every cycle that start is high, back to back.
// The operands hold quaternion A, quaternion B and the blend factor in Q1.16;
// a blend above 1.0 is treated as 1.0.
// Output: done is high for exactly one cycle with the interpolated quaternion on
// result. A beat is registered in stage 0 and then passes through the product, dot,
// square, residual, length, square-root, CORDIC, division, multiply and output
// stages in order; result shows the output stage.
// Throughput is one beat per cycle: the square roots, the CORDIC angle and sine
// steps and the weight and length divisions are unrolled, one step per register stage,
// and beats flow through the 133 stages in order.
// The linear and spherical paths are both computed for every beat and the
// choice is made in the last stage.
// The receiver cannot stall; a result must be taken in its done cycle.
// Reset clears the valid bits of all stages, so beats in flight are dropped.
`include "quaternion_slerp_unit_defines.svh"

module quaternion_slerp_unit #(
    parameter int FRACTION_BITS = qsu_pkg::FRACTION_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  qsu_pkg::in_t   operands,
    output logic           done,
    output qsu_pkg::out_t  result
);

    localparam int LAST = qsu_pkg::LAST_STAGE;

    qsu_pkg::pipe_t stage_reg [0:LAST];
    qsu_pkg::pipe_t stage_next [0:LAST];
    logic [LAST:0]  valid_reg;
    logic [LAST:0]  valid_next;

    assign busy = 1'b0;
    assign valid_next = {valid_reg[LAST-1:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g <= LAST; g++)
            stage_reg[g] <= stage_next[g];
    end

    always_comb
    begin
        stage_next[0] = '0;
        stage_next[0].qa[0] = operands.first_x;
        stage_next[0].qa[1] = operands.first_y;
        stage_next[0].qa[2] = operands.first_z;
        stage_next[0].qa[3] = operands.first_w;
        stage_next[0].qb[0] = {operands.second_x[15], operands.second_x};
        stage_next[0].qb[1] = {operands.second_y[15], operands.second_y};
        stage_next[0].qb[2] = {operands.second_z[15], operands.second_z};
        stage_next[0].qb[3] = {operands.second_w[15], operands.second_w};
        if (operands.blend > qsu_pkg::BLEND_ONE)
            stage_next[0].t = qsu_pkg::BLEND_ONE;
        else
            stage_next[0].t = operands.blend;
    end

    for (genvar g = 1; g <= LAST; g++)
    begin : g_stage
        if (g == qsu_pkg::ST_PROD)
        begin : g_prod
            logic signed [33:0] dprod [4];
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                for (int i = 0; i < 4; i++)
                begin
                    dprod[i] = $signed(stage_reg[g-1].qa[i])
                             * $signed(stage_reg[g-1].qb[i]);
                    stage_next[g].dp[i] = dprod[i];
                end
            end
        end
        else if (g == qsu_pkg::ST_DOT)
        begin : g_dot
            logic signed [33:0] dot;
            logic signed [33:0] dot_abs;
            logic signed [16:0] qb_neg [4];
            logic [63:0]        dq_wide;
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                dot = $signed(stage_reg[g-1].dp[0]) + $signed(stage_reg[g-1].dp[1])
                    + $signed(stage_reg[g-1].dp[2]) + $signed(stage_reg[g-1].dp[3]);
                dot_abs = dot[33] ? -dot : dot;
                for (int i = 0; i < 4; i++)
                begin
                    qb_neg[i] = -$signed(stage_reg[g-1].qb[i]);
                    if (dot[33])
                        stage_next[g].qb[i] = qb_neg[i];
                end
                if (2 * FRACTION_BITS >= qsu_pkg::WORK_BITS)
                    dq_wide = {31'd0, dot_abs[32:0]}
                            >> (2 * FRACTION_BITS - qsu_pkg::WORK_BITS);
                else
                    dq_wide = {31'd0, dot_abs[32:0]}
                            << (qsu_pkg::WORK_BITS - 2 * FRACTION_BITS);
                stage_next[g].near = dq_wide > {34'd0, qsu_pkg::NEAR_LIMIT};
                stage_next[g].dq = dq_wide[29:0];
            end
        end
        else if (g == qsu_pkg::ST_SQ)
        begin : g_sq
            logic signed [17:0] diff [4];
            logic signed [35:0] lprod [4];
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                stage_next[g].dsq = stage_reg[g-1].dq * stage_reg[g-1].dq;
                for (int i = 0; i < 4; i++)
                begin
                    diff[i] = $signed(stage_reg[g-1].qb[i]) - $signed(stage_reg[g-1].qa[i]);
                    lprod[i] = diff[i] * $signed({1'b0, stage_reg[g-1].t});
                    stage_next[g].lp[i] = lprod[i];
                end
            end
        end
        else if (g == qsu_pkg::ST_RES)
        begin : g_res
            logic signed [35:0] rnd [4];
            logic signed [35:0] step [4];
            logic signed [17:0] rval [4];
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                stage_next[g].sroot.rem = (62'd1 << 60) - {2'd0, stage_reg[g-1].dsq};
                stage_next[g].sroot.root = '0;
                for (int i = 0; i < 4; i++)
                begin
                    rnd[i] = $signed(stage_reg[g-1].lp[i]) + 36'sd32768;
                    step[i] = rnd[i] >>> 16;
                    rval[i] = $signed(stage_reg[g-1].qa[i]) + $signed(step[i][17:0]);
                    stage_next[g].res[i] = rval[i];
                end
            end
        end
        else if (g == qsu_pkg::ST_RSQ)
        begin : g_rsq
            logic signed [35:0] rsq [4];
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                for (int i = 0; i < 4; i++)
                begin
                    rsq[i] = $signed(stage_reg[g-1].res[i]) * $signed(stage_reg[g-1].res[i]);
                    stage_next[g].sq[i] = rsq[i];
                end
            end
        end
        else if (g == qsu_pkg::ST_LEN)
        begin : g_len
            logic [37:0] len2;
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                len2 = {2'd0, stage_reg[g-1].sq[0]} + {2'd0, stage_reg[g-1].sq[1]}
                     + {2'd0, stage_reg[g-1].sq[2]} + {2'd0, stage_reg[g-1].sq[3]};
                stage_next[g].zero = len2 == '0;
                stage_next[g].lroot.rem = {8'd0, len2, 16'd0};
                stage_next[g].lroot.root = '0;
            end
        end
        else if (g >= qsu_pkg::ISQ0 && g <= qsu_pkg::ISQ_LAST)
        begin : g_isqrt
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                stage_next[g].sroot = qsu_pkg::root_step(stage_reg[g-1].sroot,
                                                         qsu_pkg::ISQ_LAST - g);
                stage_next[g].lroot = qsu_pkg::root_step(stage_reg[g-1].lroot,
                                                         qsu_pkg::ISQ_LAST - g);
            end
        end
        else if (g >= qsu_pkg::CV0 && g <= qsu_pkg::CV_LAST)
        begin : g_vector
            qsu_pkg::cordic_t vin;
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                if (g == qsu_pkg::CV0)
                begin
                    vin.x = {4'd0, stage_reg[g-1].dq};
                    vin.y = {3'd0, stage_reg[g-1].sroot.root};
                    vin.z = '0;
                end
                else
                    vin = stage_reg[g-1].vec;
                stage_next[g].vec = qsu_pkg::vector_step(vin, g - qsu_pkg::CV0);
            end
        end
        else if (g == qsu_pkg::ST_SPLIT)
        begin : g_split
            logic signed [50:0] tmul;
            logic signed [50:0] tshift;
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                tmul = $signed(stage_reg[g-1].vec.z) * $signed({1'b0, stage_reg[g-1].t});
                tshift = tmul >>> 16;
                stage_next[g].tt = tshift[32:0];
            end
        end
        else if (g >= qsu_pkg::RT0 && g <= qsu_pkg::RT_LAST)
        begin : g_rotate
            qsu_pkg::cordic_t ain;
            qsu_pkg::cordic_t bin;
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                if (g == qsu_pkg::RT0)
                begin
                    ain.x = qsu_pkg::CORDIC_START;
                    ain.y = '0;
                    ain.z = stage_reg[g-1].vec.z - stage_reg[g-1].tt;
                    bin.x = qsu_pkg::CORDIC_START;
                    bin.y = '0;
                    bin.z = stage_reg[g-1].tt;
                end
                else
                begin
                    ain = stage_reg[g-1].rota;
                    bin = stage_reg[g-1].rotb;
                end
                stage_next[g].rota = qsu_pkg::rotate_step(ain, g - qsu_pkg::RT0);
                stage_next[g].rotb = qsu_pkg::rotate_step(bin, g - qsu_pkg::RT0);
            end
        end
        else if (g >= qsu_pkg::DV0 && g <= qsu_pkg::DV_LAST)
        begin : g_divide
            qsu_pkg::div_t      din [6];
            logic signed [33:0] ymag [2];
            logic signed [17:0] rmag [4];
            logic [62:0]        num [6];
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                ymag[0] = $signed(stage_reg[g-1].rota.y);
                ymag[1] = $signed(stage_reg[g-1].rotb.y);
                for (int j = 0; j < 2; j++)
                begin
                    if (ymag[j][33])
                        ymag[j] = -ymag[j];
                    num[j] = {ymag[j][32:0], 30'd0};
                end
                for (int i = 0; i < 4; i++)
                begin
                    rmag[i] = $signed(stage_reg[g-1].res[i]);
                    if (rmag[i][17])
                        rmag[i] = -rmag[i];
                    num[2+i] = ({45'd0, rmag[i]} << (FRACTION_BITS + 8))
                             + {33'd0, stage_reg[g-1].lroot.root[30:1]};
                end
                for (int j = 0; j < 6; j++)
                begin
                    if (g == qsu_pkg::DV0)
                    begin
                        din[j].rem = {1'b0, num[j][62:32]};
                        din[j].lo = num[j][31:0];
                        din[j].quo = '0;
                    end
                    else
                        din[j] = stage_reg[g-1].dv[j];
                    if (j < 2)
                        stage_next[g].dv[j] = qsu_pkg::div_step(din[j],
                                                                stage_reg[g-1].sroot.root);
                    else
                        stage_next[g].dv[j] = qsu_pkg::div_step(din[j],
                                                                stage_reg[g-1].lroot.root);
                end
                if (g == qsu_pkg::DV0)
                begin
                    stage_next[g].dneg[0] = stage_reg[g-1].rota.y[33];
                    stage_next[g].dneg[1] = stage_reg[g-1].rotb.y[33];
                    for (int i = 0; i < 4; i++)
                        stage_next[g].dneg[2+i] = stage_reg[g-1].res[i][17];
                end
            end
        end
        else if (g == qsu_pkg::ST_MUL)
        begin : g_mul
            logic signed [32:0] wa;
            logic signed [32:0] wb;
            logic signed [50:0] pa [4];
            logic signed [50:0] pb [4];
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                wa = $signed({1'b0, stage_reg[g-1].dv[0].quo});
                wb = $signed({1'b0, stage_reg[g-1].dv[1].quo});
                if (stage_reg[g-1].dneg[0])
                    wa = -wa;
                if (stage_reg[g-1].dneg[1])
                    wb = -wb;
                for (int i = 0; i < 4; i++)
                begin
                    pa[i] = $signed(stage_reg[g-1].qa[i]) * wa;
                    pb[i] = $signed(stage_reg[g-1].qb[i]) * wb;
                    stage_next[g].pa[i] = pa[i];
                    stage_next[g].pb[i] = pb[i];
                end
            end
        end
        else
        begin : g_out
            logic signed [51:0] ssum [4];
            logic signed [63:0] sval [4];
            logic signed [63:0] lval [4];
            always_comb
            begin
                stage_next[g] = stage_reg[g-1];
                for (int i = 0; i < 4; i++)
                begin
                    ssum[i] = $signed(stage_reg[g-1].pa[i]) + $signed(stage_reg[g-1].pb[i])
                            + 52'sd536870912;
                    sval[i] = $signed({{12{ssum[i][51]}}, ssum[i]}) >>> qsu_pkg::WORK_BITS;
                    lval[i] = $signed({32'd0, stage_reg[g-1].dv[2+i].quo});
                    if (stage_reg[g-1].dneg[2+i])
                        lval[i] = -lval[i];
                    if (stage_reg[g-1].zero)
                        lval[i] = '0;
                    stage_next[g].o[i] = qsu_pkg::saturate_one(
                        stage_reg[g-1].near ? lval[i] : sval[i], FRACTION_BITS);
                end
            end
        end
    end

    assign done = valid_reg[LAST];
    assign result.out_x = stage_reg[LAST].o[0];
    assign result.out_y = stage_reg[LAST].o[1];
    assign result.out_z = stage_reg[LAST].o[2];
    assign result.out_w = stage_reg[LAST].o[3];

    // A floor square root leaves a remainder of at most twice the root.
    logic isqrt_ok;
    logic divide_ok;
    logic linear_ok;
    logic last_valid;
    logic last_near;
    logic last_zero;

    assign isqrt_ok =
        (stage_reg[qsu_pkg::ISQ_LAST].sroot.rem
            <= ({31'd0, stage_reg[qsu_pkg::ISQ_LAST].sroot.root} << 1))
        && (stage_reg[qsu_pkg::ISQ_LAST].lroot.rem
            <= ({31'd0, stage_reg[qsu_pkg::ISQ_LAST].lroot.root} << 1));
    assign divide_ok =
        (stage_reg[qsu_pkg::DV_LAST].dv[0].rem
            < {1'b0, stage_reg[qsu_pkg::DV_LAST].sroot.root})
        && (stage_reg[qsu_pkg::DV_LAST].dv[1].rem
            < {1'b0, stage_reg[qsu_pkg::DV_LAST].sroot.root});
    assign linear_ok =
        (stage_reg[qsu_pkg::DV_LAST].dv[2].quo <= (32'd1 << FRACTION_BITS))
        && (stage_reg[qsu_pkg::DV_LAST].dv[3].quo <= (32'd1 << FRACTION_BITS))
        && (stage_reg[qsu_pkg::DV_LAST].dv[4].quo <= (32'd1 << FRACTION_BITS))
        && (stage_reg[qsu_pkg::DV_LAST].dv[5].quo <= (32'd1 << FRACTION_BITS));
    assign last_valid = valid_reg[qsu_pkg::DV_LAST];
    assign last_near = stage_reg[qsu_pkg::DV_LAST].near;
    assign last_zero = stage_reg[qsu_pkg::DV_LAST].zero;

    `QSU_ASSERT_NEXT(a_isqrt_floor, valid_reg[qsu_pkg::ISQ_LAST-1], isqrt_ok, "root remainder")
    `QSU_ASSERT_NOW(a_weight_range, last_valid && !last_near, divide_ok, "weight overflow")
    `QSU_ASSERT_NOW(a_linear_unit, last_valid && last_near && !last_zero, linear_ok, "above one")

endmodule
